/* rtl/rid_pkg.sv */
// Shared types and constants for the recent identifier duplicate filter.
// Used by rid_ctrl, rid_dp and recent_id_dedup_filter; depends on nothing.
package rid_pkg;

  localparam int RID_DEPTH = 64;   // default ring depth
  localparam int ID_W      = 64;   // message identifier width
  localparam int OUT_W     = 8;    // result tdata width (is_new padded to a byte)

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch a new request
    logic scan;      // step the ring scan
    logic insert;    // write the identifier at the write pointer
    logic set_res;   // capture res_val as the pending result
    logic res_val;
    logic load_out;  // move the pending result into the output register
  } rid_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic id_zero;    // latched identifier is zero
    logic empty;      // nothing remembered yet
    logic scan_done;  // scan reached a match or the last filled entry
    logic hit;        // scan found a match
    logic out_free;   // output register can take a result this cycle
  } rid_sts_t;

endpackage

/* rtl/rid_ctrl.sv */
// Control state machine for the recent identifier duplicate filter.
// Depends on rid_pkg; drives rid_dp through rid_cmd_t and reads rid_sts_t.
module rid_ctrl
  import rid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  rid_sts_t sts,
  output rid_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.id_zero) begin
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b1;
          state_nxt   = ST_DONE;
        end else if (sts.empty) begin
          cmd.insert  = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.set_res = 1'b1;
          cmd.res_val = !sts.hit;
          cmd.insert  = !sts.hit;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rid_dp.sv */
// Datapath for the recent identifier duplicate filter: identifier ring memory,
// write pointer, fill count, scan counter and output register. Depends on rid_pkg.
module rid_dp
  import rid_pkg::*;
#(
  parameter int DEPTH = RID_DEPTH
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ID_W-1:0] in_id,
  input  rid_cmd_t        cmd,
  output rid_sts_t        sts,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic            out_is_new
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [ID_W-1:0] mem [DEPTH];

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] rdata_r;
  logic [AW-1:0]   wp_r;
  logic [FW-1:0]   fill_r;
  logic [AW-1:0]   scan_addr_r;
  logic            iss_done_r;
  logic            rd_pend_r;
  logic            rd_last_r;
  logic            res_r;
  logic            out_valid_r;
  logic            out_is_new_r;
  logic            match;
  logic            addr_last;

  assign match     = (rdata_r == id_r);
  assign addr_last = (FW'(scan_addr_r) == (fill_r - FW'(1)));

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem[wp_r] <= id_r;
    end
    if (cmd.scan && !iss_done_r) begin
      rdata_r <= mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_r <= in_id;
    end
    if (cmd.set_res) begin
      res_r <= cmd.res_val;
    end
    if (cmd.load_out) begin
      out_is_new_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      scan_addr_r <= '0;
      iss_done_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.insert) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
        if (fill_r != FW'(DEPTH)) begin
          fill_r <= fill_r + FW'(1);
        end
      end
      if (cmd.start) begin
        scan_addr_r <= '0;
        iss_done_r  <= 1'b0;
        rd_pend_r   <= 1'b0;
        rd_last_r   <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend_r <= !iss_done_r;
        if (!iss_done_r) begin
          rd_last_r <= addr_last;
          if (addr_last) begin
            iss_done_r <= 1'b1;
          end else begin
            scan_addr_r <= scan_addr_r + AW'(1);
          end
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.id_zero   = (id_r == '0);
  assign sts.empty     = (fill_r == '0);
  assign sts.scan_done = rd_pend_r && (rd_last_r || match);
  assign sts.hit       = rd_pend_r && match;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_is_new = out_is_new_r;

endmodule

/* rtl/recent_id_dedup_filter.sv */
// Top level of the recent identifier duplicate filter: controller plus datapath.
// Depends on rid_pkg, rid_ctrl and rid_dp.
//
//  channel  | dir | tdata fields (low bit up)      | accepted when
//  ---------+-----+--------------------------------+----------------------------
//  in_      | in  | message_id[63:0]               | in_tvalid && in_tready
//  out_     | out | is_new[0], zero pad [7:1]      | out_tvalid && out_tready
//
// One request at a time. A request skips the scan when its identifier is zero
// or nothing is remembered yet, and otherwise scans at most fill entries (at most
// DEPTH): the scan reads one ring entry per cycle through the single
// registered read port of the ring memory, stopping early at a match.
// The output register holds a finished result, so the next request can be
// taken while the previous result waits for out_tready.
// rst_n is synchronous and active low; it clears the write pointer and the fill
// count, which marks every ring entry as unwritten at once (no clearing pass).
module recent_id_dedup_filter
  import rid_pkg::*;
#(
  parameter int DEPTH = RID_DEPTH
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ID_W-1:0]  in_tdata,    // [63:0] message_id
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata    // [0] is_new, [7:1] zero
);

  rid_cmd_t cmd;
  rid_sts_t sts;
  logic     is_new;

  // sequence the request: check, scan, insert, hand off the result
  rid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the ring, the pointers and the output register
  rid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_id      (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_is_new (is_new)
  );

  assign out_tdata = {{(OUT_W - 1){1'b0}}, is_new};

  // only one request in flight: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // never store an identifier that the scan just matched
  a_no_dup_insert: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.hit)
    else $error("duplicate identifier written to the ring");

  // never overwrite a result that has not been taken
  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

endmodule
